/* src/rnc_pkg.sv */
// Shared types, constants and the offset table for the raster neighbour cell block.
package rnc_pkg;

   localparam int DIM_BITS = 16;
   localparam int CELL_W   = 32;
   localparam int CSR_W    = 16;
   localparam int IDX_W    = 3;
   localparam int CNT_W    = 5;
   localparam int PROD_W   = 2 * DIM_BITS;
   localparam int CMP_W    = (PROD_W > CELL_W) ? PROD_W : CELL_W;
   localparam int SDIM_W   = DIM_BITS + 2;

   // register indexes of the configuration port
   localparam logic [IDX_W-1:0] REG_NUM_ROWS       = 3'd0;
   localparam logic [IDX_W-1:0] REG_NUM_COLS       = 3'd1;
   localparam logic [IDX_W-1:0] REG_NEIGHBOR_MODE  = 3'd2;
   localparam logic [IDX_W-1:0] REG_INCLUDE_CENTER = 3'd3;
   localparam logic [IDX_W-1:0] REG_WRAP_COLUMNS   = 3'd4;

   typedef enum logic [1:0] {
      MODE_ROOK    = 2'd0,
      MODE_QUEEN   = 2'd1,
      MODE_BISHOP  = 2'd2,
      MODE_SIXTEEN = 2'd3
   } mode_type;

   // one classified cell handed from front to back
   typedef struct packed {
      logic [DIM_BITS-1:0] row;
      logic [DIM_BITS-1:0] col;
      logic                ok;
   } entry_type;

   typedef struct packed {
      logic signed [2:0] dr;
      logic signed [2:0] dc;
   } offset_type;

   // number of neighbours in a mode, centre excluded
   function automatic logic [CNT_W-1:0] mode_count(mode_type mode);
      logic [CNT_W-1:0] n;
      unique case (mode)
         MODE_ROOK:    n = 5'd4;
         MODE_QUEEN:   n = 5'd8;
         MODE_BISHOP:  n = 5'd4;
         MODE_SIXTEEN: n = 5'd16;
         default:      n = 5'd4;
      endcase
      return n;
   endfunction

   function automatic offset_type mk(int r, int c);
      offset_type o;
      o.dr = 3'(r);
      o.dc = 3'(c);
      return o;
   endfunction

   // offset of neighbour k; anything past the list is the centre
   function automatic offset_type neighbor_offset(mode_type mode, logic [CNT_W-1:0] k);
      offset_type o;
      o = mk(0, 0);
      unique case (mode)
         MODE_ROOK: begin
            case (k)
               5'd0: o = mk(-1, 0);
               5'd1: o = mk(0, -1);
               5'd2: o = mk(0, 1);
               5'd3: o = mk(1, 0);
               default: o = mk(0, 0);
            endcase
         end
         MODE_QUEEN: begin
            case (k)
               5'd0: o = mk(-1, -1);
               5'd1: o = mk(-1, 0);
               5'd2: o = mk(-1, 1);
               5'd3: o = mk(0, -1);
               5'd4: o = mk(0, 1);
               5'd5: o = mk(1, -1);
               5'd6: o = mk(1, 0);
               5'd7: o = mk(1, 1);
               default: o = mk(0, 0);
            endcase
         end
         MODE_BISHOP: begin
            case (k)
               5'd0: o = mk(-1, -1);
               5'd1: o = mk(-1, 1);
               5'd2: o = mk(1, -1);
               5'd3: o = mk(1, 1);
               default: o = mk(0, 0);
            endcase
         end
         MODE_SIXTEEN: begin
            case (k)
               5'd0:  o = mk(-2, -1);
               5'd1:  o = mk(-2, 1);
               5'd2:  o = mk(-1, -2);
               5'd3:  o = mk(-1, -1);
               5'd4:  o = mk(-1, 0);
               5'd5:  o = mk(-1, 1);
               5'd6:  o = mk(-1, 2);
               5'd7:  o = mk(0, -1);
               5'd8:  o = mk(0, 1);
               5'd9:  o = mk(1, -2);
               5'd10: o = mk(1, -1);
               5'd11: o = mk(1, 0);
               5'd12: o = mk(1, 1);
               5'd13: o = mk(1, 2);
               5'd14: o = mk(2, -1);
               5'd15: o = mk(2, 1);
               default: o = mk(0, 0);
            endcase
         end
         default: o = mk(0, 0);
      endcase
      return o;
   endfunction

endpackage

/* src/rnc_front.sv */
// Front end: takes a cell number, checks it against the grid and splits it into row and column.
module rnc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rnc_pkg::CELL_W-1:0]    req_cell_number,
   input  logic [rnc_pkg::DIM_BITS-1:0]  num_rows,
   input  logic [rnc_pkg::DIM_BITS-1:0]  num_cols,
   output logic                          push,
   output rnc_pkg::entry_type            push_entry,
   input  logic                          q_full
);
   import rnc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_PUSH
   } state_type;

   localparam int STEP_W = $clog2(DIM_BITS + 1);

   state_type           state_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [DIM_BITS-1:0] rem_ff;
   logic [DIM_BITS-1:0] dvd_ff;
   logic [DIM_BITS-1:0] quo_ff;
   logic                ok_ff;

   logic [CMP_W-1:0]    grid_size;
   logic                cell_ok;
   logic [DIM_BITS:0]   trial;
   logic                qbit;
   logic [DIM_BITS-1:0] rem_in;

   // grid bound check at acceptance
   assign grid_size = CMP_W'(num_rows) * CMP_W'(num_cols);
   assign cell_ok   = CMP_W'(req_cell_number) < grid_size;

   // one restoring division step per cycle
   always_comb begin
      trial  = {rem_ff, dvd_ff[DIM_BITS-1]};
      qbit   = trial >= {1'b0, num_cols};
      rem_in = qbit ? DIM_BITS'(trial - {1'b0, num_cols}) : trial[DIM_BITS-1:0];
   end

   assign busy             = state_ff != ST_IDLE;
   assign push             = (state_ff == ST_PUSH) && !q_full;
   assign push_entry.row   = quo_ff;
   assign push_entry.col   = rem_ff;
   assign push_entry.ok    = ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  // quotient fits DIM_BITS whenever the cell is on the grid
                  rem_ff   <= DIM_BITS'(req_cell_number >> DIM_BITS);
                  dvd_ff   <= req_cell_number[DIM_BITS-1:0];
                  quo_ff   <= '0;
                  ok_ff    <= cell_ok;
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= rem_in;
               dvd_ff  <= {dvd_ff[DIM_BITS-2:0], 1'b0};
               quo_ff  <= {quo_ff[DIM_BITS-2:0], qbit};
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(DIM_BITS - 1)) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (!q_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* src/rnc_queue.sv */
// Two-entry queue between the front and back ends.
module rnc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rnc_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output rnc_pkg::entry_type pop_entry,
   output logic               not_empty
);
   import rnc_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   // store payload without reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

/* src/rnc_back.sv */
// Back end: walks the offset list of one cell and emits a result each cycle while active.
module rnc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rnc_pkg::DIM_BITS-1:0]  num_rows,
   input  logic [rnc_pkg::DIM_BITS-1:0]  num_cols,
   input  rnc_pkg::mode_type             mode,
   input  logic                          include_center,
   input  logic                          wrap_columns,
   input  logic                          q_not_empty,
   input  rnc_pkg::entry_type            q_entry,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic [rnc_pkg::CELL_W-1:0]    rsp_neighbor_cell,
   output logic                          rsp_neighbor_valid,
   output logic                          rsp_last_neighbor
);
   import rnc_pkg::*;

   logic                active_ff;
   entry_type           entry_ff;
   logic [CNT_W-1:0]    k_ff;
   logic [CNT_W-1:0]    total_ff;

   logic                s1_valid_ff;
   logic [DIM_BITS-1:0] s1_row_ff;
   logic [DIM_BITS-1:0] s1_col_ff;
   logic                s1_ok_ff;
   logic                s1_last_ff;

   offset_type          ofs;
   logic                last_k;
   logic signed [SDIM_W-1:0] rr;
   logic signed [SDIM_W-1:0] cc_raw;
   logic signed [SDIM_W-1:0] cc;
   logic signed [SDIM_W-1:0] rows_s;
   logic signed [SDIM_W-1:0] cols_s;
   logic                nb_ok;
   logic [CMP_W-1:0]    cell_sum;

   assign last_k = k_ff == (total_ff - 5'd1);
   assign pop    = q_not_empty && (!active_ff || last_k);

   // neighbour coordinates with optional column wrap
   always_comb begin
      ofs    = neighbor_offset(mode, k_ff);
      rows_s = $signed({2'b00, num_rows});
      cols_s = $signed({2'b00, num_cols});
      rr     = $signed({2'b00, entry_ff.row}) + $signed({{(DIM_BITS-1){ofs.dr[2]}}, ofs.dr});
      cc_raw = $signed({2'b00, entry_ff.col}) + $signed({{(DIM_BITS-1){ofs.dc[2]}}, ofs.dc});
      cc     = cc_raw;
      if (wrap_columns) begin
         priority if (cc_raw < 0)       cc = cc_raw + cols_s;
         else if (cc_raw >= cols_s)     cc = cc_raw - cols_s;
         else                           cc = cc_raw;
      end
      nb_ok = entry_ff.ok && (rr >= 0) && (rr < rows_s) && (cc >= 0) && (cc < cols_s);
   end

   // sequence through the offsets of the current cell
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         if (pop) begin
            active_ff <= 1'b1;
            entry_ff  <= q_entry;
            k_ff      <= '0;
            total_ff  <= mode_count(mode) + CNT_W'(include_center);
         end else if (active_ff) begin
            if (last_k) active_ff <= 1'b0;
            k_ff <= k_ff + 5'd1;
         end
      end
   end

   // stage one: coordinates and validity
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= active_ff;
      end
      s1_row_ff  <= rr[DIM_BITS-1:0];
      s1_col_ff  <= cc[DIM_BITS-1:0];
      s1_ok_ff   <= nb_ok;
      s1_last_ff <= last_k;
   end

   assign cell_sum = CMP_W'(s1_row_ff) * CMP_W'(num_cols) + CMP_W'(s1_col_ff);

   // stage two: row-major index into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= s1_valid_ff;
      end
      rsp_neighbor_cell  <= s1_ok_ff ? cell_sum[CELL_W-1:0] : '0;
      rsp_neighbor_valid <= s1_ok_ff;
      rsp_last_neighbor  <= s1_last_ff;
   end

endmodule

/* src/raster_neighbor_cells_core.sv */
// Top level of the raster neighbour cell block: configuration and the two ends.
// A cell passes the front end's divider, the queue and two back-end stages before its
//   results appear, then one per cycle. Throughput is set by the front end's 16-step
//   divider; a cell yields 4 to 17 results, so the back end keeps pace.
// The receiver cannot stall; results appear for one cycle with rsp_strobe.
// Synchronous reset clears control state and sets the grid to one row, one column.
module raster_neighbor_cells_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rnc_pkg::CELL_W-1:0]    req_cell_number,
   output logic                          rsp_strobe,
   output logic [rnc_pkg::CELL_W-1:0]    rsp_neighbor_cell,
   output logic                          rsp_neighbor_valid,
   output logic                          rsp_last_neighbor,
   input  logic                          csr_we,
   input  logic [rnc_pkg::IDX_W-1:0]     csr_index,
   input  logic [rnc_pkg::CSR_W-1:0]     csr_wdata
);
   import rnc_pkg::*;

   logic [DIM_BITS-1:0] num_rows_ff;
   logic [DIM_BITS-1:0] num_cols_ff;
   mode_type            mode_ff;
   logic                include_center_ff;
   logic                wrap_columns_ff;

   logic      push;
   entry_type push_entry;
   logic      q_full;
   logic      pop;
   entry_type pop_entry;
   logic      q_not_empty;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff       <= DIM_BITS'(1);
         num_cols_ff       <= DIM_BITS'(1);
         mode_ff           <= MODE_ROOK;
         include_center_ff <= 1'b0;
         wrap_columns_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_NUM_ROWS:       num_rows_ff       <= DIM_BITS'(csr_wdata);
            REG_NUM_COLS:       num_cols_ff       <= DIM_BITS'(csr_wdata);
            REG_NEIGHBOR_MODE:  mode_ff           <= mode_type'(csr_wdata[1:0]);
            REG_INCLUDE_CENTER: include_center_ff <= csr_wdata[0];
            REG_WRAP_COLUMNS:   wrap_columns_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   rnc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cell_number (req_cell_number),
      .num_rows        (num_rows_ff),
      .num_cols        (num_cols_ff),
      .push            (push),
      .push_entry      (push_entry),
      .q_full          (q_full)
   );

   rnc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .not_empty  (q_not_empty)
   );

   rnc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .num_rows           (num_rows_ff),
      .num_cols           (num_cols_ff),
      .mode               (mode_ff),
      .include_center     (include_center_ff),
      .wrap_columns       (wrap_columns_ff),
      .q_not_empty        (q_not_empty),
      .q_entry            (pop_entry),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_neighbor_cell  (rsp_neighbor_cell),
      .rsp_neighbor_valid (rsp_neighbor_valid),
      .rsp_last_neighbor  (rsp_last_neighbor)
   );

endmodule

/* src/rnc_checker.sv */
// Port-level checks for the raster neighbour cell block, bound to the top level.
module rnc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [rnc_pkg::CELL_W-1:0]    rsp_neighbor_cell,
   input logic                          rsp_neighbor_valid
);

   // an accepted transaction occupies the front end next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");

   // the front end only becomes busy through an accepted transaction
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start)) else $error("busy rose without start");

   // an off-grid neighbour carries a zero index
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_neighbor_valid |-> rsp_neighbor_cell == '0)
      else $error("invalid neighbour with non-zero index");

   // no result soon after reset release
   a_quiet_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_strobe) else $error("result right after reset");

endmodule

bind raster_neighbor_cells_core rnc_checker u_rnc_checker (.*);
